/* rtl/vmu_pkg.sv */
// Package of the vector math unit: constants, command codes, pipeline types and helpers.
package vmu_pkg;

    // Fraction bits of the signed fixed-point format.
    localparam int FRAC_BITS  = 16;
    // Quotient bits of a normalized component, which never exceeds one.
    localparam int QW         = FRAC_BITS + 1;
    // One result bit of the 64-bit square root per pipeline stage.
    localparam int ROOT_STEPS = 32;

    typedef enum logic [3:0] {
        CMD_ADD     = 4'd0,
        CMD_SUB     = 4'd1,
        CMD_SCALE   = 4'd2,
        CMD_ADDS    = 4'd3,
        CMD_SUBS    = 4'd4,
        CMD_DOT     = 4'd5,
        CMD_CROSS   = 4'd6,
        CMD_LENGTH  = 4'd7,
        CMD_NORM    = 4'd8,
        CMD_LONGER  = 4'd9,
        CMD_SHORTER = 4'd10,
        CMD_MAX     = 4'd11,
        CMD_MIN     = 4'd12
    } t_cmd;

    // One result as it leaves the unit.
    typedef struct packed {
        logic signed [31:0] rx;
        logic signed [31:0] ry;
        logic signed [31:0] rz;
        logic signed [31:0] sc;
        logic               cmp;
        logic               err;
    } t_res;

    // Data that travels beside the root and divider pipelines.
    typedef struct packed {
        logic [3:0]       cmd;
        t_res             res;
        logic [2:0][31:0] mag;
        logic [2:0]       neg;
    } t_side;

    // Saturate a wide signed value to 32 bits; the top bit reports clipping.
    function automatic logic [32:0] sat32(input logic signed [65:0] v);
        logic [32:0] o;
        if (v > 66'sd2147483647) begin
            o = {1'b1, 32'h7fffffff};
        end else if (v < -66'sd2147483648) begin
            o = {1'b1, 32'h80000000};
        end else begin
            o = {1'b0, v[31:0]};
        end
        return o;
    endfunction

endpackage

/* rtl/vmu_if.sv */
// Valid/ready channel interfaces for the input and result transactions.
interface vmu_in_if;
    logic               valid;
    logic               ready;
    logic [3:0]         command;
    logic signed [31:0] ax;
    logic signed [31:0] ay;
    logic signed [31:0] az;
    logic signed [31:0] bx;
    logic signed [31:0] by;
    logic signed [31:0] bz;
    logic signed [31:0] scalar_in;

    modport source (output valid, command, ax, ay, az, bx, by, bz, scalar_in, input ready);
    modport sink (input valid, command, ax, ay, az, bx, by, bz, scalar_in, output ready);
endinterface

interface vmu_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] rx;
    logic signed [31:0] ry;
    logic signed [31:0] rz;
    logic signed [31:0] scalar_out;
    logic               compare_flag;
    logic               error_flag;

    modport source (output valid, rx, ry, rz, scalar_out, compare_flag, error_flag,
                    input ready);
    modport sink (input valid, rx, ry, rz, scalar_out, compare_flag, error_flag,
                  output ready);
endinterface

/* rtl/vmu_isqrt.sv */
// Pipelined digit-by-digit integer square root of a 64-bit value, one result bit per stage.
module vmu_isqrt (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  logic [63:0]       i_sq,
    input  vmu_pkg::t_side    i_side,
    output logic              o_valid,
    output logic [31:0]       o_root,
    output vmu_pkg::t_side    o_side
);
    import vmu_pkg::*;

    logic        r_v    [ROOT_STEPS];
    logic [63:0] r_rem  [ROOT_STEPS];
    logic [63:0] r_res  [ROOT_STEPS];
    t_side       r_side [ROOT_STEPS];

    for (genvar k = 0; k < ROOT_STEPS; k++) begin : g_step
        localparam logic [63:0] BIT = 64'd1 << (2 * (ROOT_STEPS - 1 - k));

        logic [63:0] s_in;
        logic [63:0] res_in;
        logic [63:0] trial;
        logic [63:0] n_rem;
        logic [63:0] n_res;
        logic        v_in;
        t_side       side_in;

        if (k == 0) begin : g_first
            assign s_in    = i_sq;
            assign res_in  = '0;
            assign v_in    = i_valid;
            assign side_in = i_side;
        end else begin : g_next
            assign s_in    = r_rem[k-1];
            assign res_in  = r_res[k-1];
            assign v_in    = r_v[k-1];
            assign side_in = r_side[k-1];
        end

        // Try the next root bit and keep it when the remainder allows.
        always_comb begin
            trial = res_in + BIT;
            if (s_in >= trial) begin
                n_rem = s_in - trial;
                n_res = (res_in >> 1) + BIT;
            end else begin
                n_rem = s_in;
                n_res = res_in >> 1;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_en) begin
                r_v[k] <= v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k]  <= n_rem;
                r_res[k]  <= n_res;
                r_side[k] <= side_in;
            end
        end
    end

    assign o_valid = r_v[ROOT_STEPS-1];
    assign o_root  = r_res[ROOT_STEPS-1][31:0];
    assign o_side  = r_side[ROOT_STEPS-1];

endmodule

/* rtl/vmu_ndiv.sv */
// Pipelined restoring divider that divides the three magnitudes by the vector length.
module vmu_ndiv (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_en,
    input  logic                         i_valid,
    input  logic [31:0]                  i_len,
    input  vmu_pkg::t_side               i_side,
    output logic                         o_valid,
    output logic [31:0]                  o_len,
    output logic [2:0][vmu_pkg::QW-1:0]  o_q,
    output vmu_pkg::t_side               o_side
);
    import vmu_pkg::*;

    logic                 r_v    [QW];
    logic [31:0]          r_len  [QW];
    logic [2:0][31:0]     r_rem  [QW];
    logic [2:0][QW-1:0]   r_q    [QW];
    t_side                r_side [QW];

    for (genvar j = 0; j < QW; j++) begin : g_step
        logic [31:0]        len_in;
        logic [2:0][31:0]   rem_in;
        logic [2:0][QW-1:0] q_in;
        logic [2:0]         nb;
        logic               v_in;
        t_side              side_in;
        logic [2:0][31:0]   n_rem;
        logic [2:0][QW-1:0] n_q;

        // The first stage starts from half the magnitude and shifts in its low bit.
        if (j == 0) begin : g_first
            assign len_in  = i_len;
            assign v_in    = i_valid;
            assign side_in = i_side;
            assign q_in    = '0;
            for (genvar i = 0; i < 3; i++) begin : g_lane
                assign rem_in[i] = {1'b0, i_side.mag[i][31:1]};
                assign nb[i]     = i_side.mag[i][0];
            end
        end else begin : g_next
            assign len_in  = r_len[j-1];
            assign v_in    = r_v[j-1];
            assign side_in = r_side[j-1];
            assign q_in    = r_q[j-1];
            assign rem_in  = r_rem[j-1];
            assign nb      = '0;
        end

        // One quotient bit per lane.
        always_comb begin
            logic [32:0] sh;
            for (int i = 0; i < 3; i++) begin
                sh = {rem_in[i], nb[i]};
                if (sh >= {1'b0, len_in}) begin
                    n_rem[i] = 32'(sh - {1'b0, len_in});
                    n_q[i]   = {q_in[i][QW-2:0], 1'b1};
                end else begin
                    n_rem[i] = sh[31:0];
                    n_q[i]   = {q_in[i][QW-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[j] <= 1'b0;
            end else if (i_en) begin
                r_v[j] <= v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_len[j]  <= len_in;
                r_rem[j]  <= n_rem;
                r_q[j]    <= n_q;
                r_side[j] <= side_in;
            end
        end
    end

    assign o_valid = r_v[QW-1];
    assign o_len   = r_len[QW-1];
    assign o_q     = r_q[QW-1];
    assign o_side  = r_side[QW-1];

    // A normalized component never exceeds one.
    a_q_le_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_side.cmd == CMD_NORM && o_len != 32'd0) |->
        ((!o_q[0][QW-1] || o_q[0][QW-2:0] == '0) &&
         (!o_q[1][QW-1] || o_q[1][QW-2:0] == '0) &&
         (!o_q[2][QW-1] || o_q[2][QW-2:0] == '0)))
        else $error("normalized component above one");

endmodule

/* rtl/vec3_math_unit_core.sv */
// Top level of the three-component fixed-point vector unit.
//
//   channel  dir  contents
//   i_in     in   command, vectors A and B, scalar_in
//   o_out    out  rx, ry, rz, scalar_out, compare_flag, error_flag
//
// One transaction enters per cycle while the output is not stalled; every command takes
// the same path (input, multiply, combine, 32 root stages, FRAC_BITS + 1 divider stages,
// output register).
// The 32-stage square root and the divider chain make up most of that path.
// Reset clears only the valid bits of the pipeline.
// A stall on the output freezes every stage at once; nothing is lost or repeated.
module vec3_math_unit_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    vmu_in_if.sink     i_in,
    vmu_out_if.source  o_out
);
    import vmu_pkg::*;

    logic en;

    // Stage 1: input registers.
    logic               r_s1_v;
    logic [3:0]         r_s1_cmd;
    logic signed [31:0] r_s1_a [3];
    logic signed [31:0] r_s1_b [3];
    logic signed [31:0] r_s1_s;

    // Stage 2: products.
    logic               r_s2_v;
    logic [3:0]         r_s2_cmd;
    logic signed [31:0] r_s2_a [3];
    logic signed [31:0] r_s2_b [3];
    logic signed [31:0] r_s2_s;
    logic signed [63:0] r_s2_p [6];
    logic signed [31:0] m_x [6];
    logic signed [31:0] m_y [6];

    // Stage 3: combined results.
    logic               r_s3_v;
    logic [63:0]        r_s3_sq;
    t_side              r_s3_side;
    t_side              n_s3_side;
    logic [63:0]        n_sq;

    // Root and divider pipelines.
    logic               q_valid;
    logic [31:0]        q_root;
    t_side              q_side;
    t_side              l_side;
    logic               d_valid;
    logic [31:0]        d_len;
    logic [2:0][QW-1:0] d_q;
    t_side              d_side;

    // Output register.
    logic               r_out_v;
    t_res               r_out_res;
    t_res               n_out_res;

    // The whole pipeline advances unless a finished result is held.
    assign en         = !r_out_v || o_out.ready;
    assign i_in.ready = en;

    // Capture the input transaction.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
        end else if (en) begin
            r_s1_v <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1_cmd  <= i_in.command;
            r_s1_a[0] <= i_in.ax;
            r_s1_a[1] <= i_in.ay;
            r_s1_a[2] <= i_in.az;
            r_s1_b[0] <= i_in.bx;
            r_s1_b[1] <= i_in.by;
            r_s1_b[2] <= i_in.bz;
            r_s1_s    <= i_in.scalar_in;
        end
    end

    // Steer the six multipliers by command.
    always_comb begin
        for (int k = 0; k < 6; k++) begin
            m_x[k] = '0;
            m_y[k] = '0;
        end
        case (r_s1_cmd)
            CMD_SCALE: begin
                for (int k = 0; k < 3; k++) begin
                    m_x[k] = r_s1_a[k];
                    m_y[k] = r_s1_s;
                end
            end
            CMD_DOT: begin
                for (int k = 0; k < 3; k++) begin
                    m_x[k] = r_s1_a[k];
                    m_y[k] = r_s1_b[k];
                end
            end
            CMD_CROSS: begin
                m_x[0] = r_s1_a[1]; m_y[0] = r_s1_b[2];
                m_x[1] = r_s1_a[2]; m_y[1] = r_s1_b[1];
                m_x[2] = r_s1_a[2]; m_y[2] = r_s1_b[0];
                m_x[3] = r_s1_a[0]; m_y[3] = r_s1_b[2];
                m_x[4] = r_s1_a[0]; m_y[4] = r_s1_b[1];
                m_x[5] = r_s1_a[1]; m_y[5] = r_s1_b[0];
            end
            CMD_LENGTH, CMD_NORM, CMD_LONGER, CMD_SHORTER: begin
                for (int k = 0; k < 3; k++) begin
                    m_x[k] = r_s1_a[k];
                    m_y[k] = r_s1_a[k];
                end
                m_x[3] = r_s1_s;
                m_y[3] = r_s1_s;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_v <= 1'b0;
        end else if (en) begin
            r_s2_v <= r_s1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s2_cmd <= r_s1_cmd;
            r_s2_a   <= r_s1_a;
            r_s2_b   <= r_s1_b;
            r_s2_s   <= r_s1_s;
            for (int k = 0; k < 6; k++) begin
                r_s2_p[k] <= m_x[k] * m_y[k];
            end
        end
    end

    // Combine products and operands into results, with saturation.
    always_comb begin
        logic signed [65:0] e_a [3];
        logic signed [65:0] e_b [3];
        logic signed [65:0] e_p [6];
        logic signed [65:0] e_s;
        logic signed [65:0] w [3];
        logic signed [65:0] wd;
        logic [32:0]        sv0;
        logic [32:0]        sv1;
        logic [32:0]        sv2;
        logic [32:0]        sd;
        logic               vec;
        logic               dot;

        for (int i = 0; i < 3; i++) begin
            e_a[i] = 66'(r_s2_a[i]);
            e_b[i] = 66'(r_s2_b[i]);
            w[i]   = '0;
        end
        for (int k = 0; k < 6; k++) begin
            e_p[k] = 66'(r_s2_p[k]);
        end
        e_s = 66'(r_s2_s);
        wd  = '0;
        vec = 1'b0;
        dot = 1'b0;

        n_sq = 64'(e_p[0] + e_p[1] + e_p[2]);

        n_s3_side     = '0;
        n_s3_side.cmd = r_s2_cmd;
        for (int i = 0; i < 3; i++) begin
            n_s3_side.neg[i] = r_s2_a[i][31];
            n_s3_side.mag[i] = r_s2_a[i][31] ? -r_s2_a[i] : r_s2_a[i];
        end

        case (r_s2_cmd)
            CMD_ADD: begin
                vec = 1'b1;
                for (int i = 0; i < 3; i++) w[i] = e_a[i] + e_b[i];
            end
            CMD_SUB: begin
                vec = 1'b1;
                for (int i = 0; i < 3; i++) w[i] = e_a[i] - e_b[i];
            end
            CMD_SCALE: begin
                vec = 1'b1;
                for (int i = 0; i < 3; i++) w[i] = e_p[i] >>> FRAC_BITS;
            end
            CMD_ADDS: begin
                vec = 1'b1;
                for (int i = 0; i < 3; i++) w[i] = e_a[i] + e_s;
            end
            CMD_SUBS: begin
                vec = 1'b1;
                for (int i = 0; i < 3; i++) w[i] = e_a[i] - e_s;
            end
            CMD_CROSS: begin
                vec  = 1'b1;
                w[0] = (e_p[0] - e_p[1]) >>> FRAC_BITS;
                w[1] = (e_p[2] - e_p[3]) >>> FRAC_BITS;
                w[2] = (e_p[4] - e_p[5]) >>> FRAC_BITS;
            end
            CMD_MAX: begin
                vec = 1'b1;
                for (int i = 0; i < 3; i++) w[i] = (e_a[i] > e_b[i]) ? e_a[i] : e_b[i];
            end
            CMD_MIN: begin
                vec = 1'b1;
                for (int i = 0; i < 3; i++) w[i] = (e_a[i] < e_b[i]) ? e_a[i] : e_b[i];
            end
            CMD_DOT: begin
                dot = 1'b1;
                wd  = (e_p[0] + e_p[1] + e_p[2]) >>> FRAC_BITS;
            end
            CMD_LONGER: begin
                n_s3_side.res.cmp = n_sq > 64'(r_s2_p[3]);
            end
            CMD_SHORTER: begin
                n_s3_side.res.cmp = n_sq < 64'(r_s2_p[3]);
            end
            default: begin
            end
        endcase

        sv0 = sat32(w[0]);
        sv1 = sat32(w[1]);
        sv2 = sat32(w[2]);
        sd  = sat32(wd);
        if (vec) begin
            n_s3_side.res.rx  = sv0[31:0];
            n_s3_side.res.ry  = sv1[31:0];
            n_s3_side.res.rz  = sv2[31:0];
            n_s3_side.res.err = sv0[32] | sv1[32] | sv2[32];
        end
        if (dot) begin
            n_s3_side.res.sc  = sd[31:0];
            n_s3_side.res.err = sd[32];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_v <= 1'b0;
        end else if (en) begin
            r_s3_v <= r_s2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s3_sq   <= n_sq;
            r_s3_side <= n_s3_side;
        end
    end

    // Square root of the sum of squares.
    vmu_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_s3_v),
        .i_sq    (r_s3_sq),
        .i_side  (r_s3_side),
        .o_valid (q_valid),
        .o_root  (q_root),
        .o_side  (q_side)
    );

    // Length result, clipped when the root exceeds the signed range.
    always_comb begin
        l_side = q_side;
        if (q_side.cmd == CMD_LENGTH) begin
            if (q_root[31]) begin
                l_side.res.sc  = 32'sh7fffffff;
                l_side.res.err = 1'b1;
            end else begin
                l_side.res.sc  = q_root;
            end
        end
    end

    // Divide each magnitude, scaled to the fraction, by the length.
    vmu_ndiv u_ndiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (q_valid),
        .i_len   (q_root),
        .i_side  (l_side),
        .o_valid (d_valid),
        .o_len   (d_len),
        .o_q     (d_q),
        .o_side  (d_side)
    );

    // Apply signs to the normalized components; a zero vector flags an error.
    always_comb begin
        logic signed [31:0] qe [3];
        for (int i = 0; i < 3; i++) begin
            qe[i] = 32'(d_q[i]);
            if (d_side.neg[i]) begin
                qe[i] = -qe[i];
            end
        end
        n_out_res = d_side.res;
        if (d_side.cmd == CMD_NORM) begin
            if (d_len == 32'd0) begin
                n_out_res.err = 1'b1;
            end else begin
                n_out_res.rx = qe[0];
                n_out_res.ry = qe[1];
                n_out_res.rz = qe[2];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (en) begin
            r_out_v <= d_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_res <= n_out_res;
        end
    end

    assign o_out.valid        = r_out_v;
    assign o_out.rx           = r_out_res.rx;
    assign o_out.ry           = r_out_res.ry;
    assign o_out.rz           = r_out_res.rz;
    assign o_out.scalar_out   = r_out_res.sc;
    assign o_out.compare_flag = r_out_res.cmp;
    assign o_out.error_flag   = r_out_res.err;

    // An empty output register always lets the pipeline move.
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out.valid |-> i_in.ready)
        else $error("input stalled with empty output register");

    // A compare result carries nothing else.
    a_cmp_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.compare_flag) |->
        (o_out.rx == 32'sd0 && o_out.ry == 32'sd0 && o_out.rz == 32'sd0 &&
         o_out.scalar_out == 32'sd0 && !o_out.error_flag))
        else $error("compare result with other fields set");

    // Reset empties the output register.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out.valid)
        else $error("output valid after reset");

endmodule
